/* design/fscc_pkg.sv */
// Package: command codes, state record and the arithmetic maps of the fan speed controller.
package fscc_pkg;

   typedef enum logic [1:0] {
      FUNC_TARGET  = 2'd0,
      FUNC_PERCENT = 2'd1,
      FUNC_ON_OFF  = 2'd2,
      FUNC_REFRESH = 2'd3
   } func_type;

   typedef struct packed {
      logic        on;
      logic [6:0]  percent;
      logic [11:0] target;
      logic [11:0] shown;
   } fan_state_type;

   localparam logic [11:0] RPM_MIN       = 12'd500;
   localparam logic [11:0] RPM_MAX       = 12'd2800;
   localparam logic [11:0] RPM_RESET     = 12'd800;
   localparam logic [6:0]  PCT_MAX       = 7'd100;
   localparam logic [6:0]  PCT_RESET     = 7'd30;
   localparam logic [6:0]  PCT_DEFAULT   = 7'd30;
   localparam logic [6:0]  PCT_FLOOR     = 7'd15;
   localparam logic [7:0]  DUTY_MIN      = 8'd30;
   localparam logic [7:0]  DUTY_MAX      = 8'd250;
   localparam logic [7:0]  DUTY_FULL     = 8'd255;

   // Reciprocals: floor(n/d) = (n*m) >> s, exact over the operand ranges used here.
   localparam logic [15:0] TGT_RECIP  = 16'd36473; // 1/460, s = 24, n <= 39100
   localparam logic [11:0] RPM_RECIP  = 12'd2622;  // 1/100, s = 18, n <= 2849
   localparam logic [9:0]  DUTY_RECIP = 10'd662;   // 1/99,  s = 16, n <= 21780

   // (t-500)*85/2300 + 15, with 85/2300 reduced to 17/460.
   function automatic logic [6:0] percent_of_target(logic [11:0] t);
      logic [11:0] d;
      logic [15:0] n;
      logic [31:0] prod;
      d    = t - RPM_MIN;
      n    = 16'(d) * 16'd17;
      prod = 32'(n) * 32'(TGT_RECIP);
      return 7'(prod[31:24]) + PCT_FLOOR;
   endfunction

   // ((p*28 + 49) / 100) * 100; never exceeds 2800 for p <= 100.
   function automatic logic [11:0] rpm_of_percent(logic [6:0] p);
      logic [11:0] n;
      logic [22:0] prod;
      logic [4:0]  q;
      n    = 12'(p) * 12'd28 + 12'd49;
      prod = 23'(n) * 23'(RPM_RECIP);
      q    = prod[22:18];
      return (p == 7'd0) ? 12'd0 : 12'(q) * 12'd100;
   endfunction

   // (p-1)*220/99 + 30, zero when off or at zero percent.
   function automatic logic [7:0] duty_of_percent(logic on, logic [6:0] p);
      logic [14:0] n;
      logic [24:0] prod;
      n    = 15'(p - 7'd1) * 15'd220;
      prod = 25'(n) * 25'(DUTY_RECIP);
      return (!on || p == 7'd0) ? 8'd0 : 8'(prod[24:16]) + DUTY_MIN;
   endfunction

endpackage

/* design/fscc_req_if.sv */
// Interface: command channel (valid/ready with func and value).
interface fscc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

/* design/fscc_rsp_if.sv */
// Interface: result channel (valid/ready with duty, shown rpm, percent and on flag).
interface fscc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  duty;
   logic [11:0] shown_rpm;
   logic [6:0]  speed_percent;
   logic        fan_enabled;

   modport source (output valid, output duty, output shown_rpm, output speed_percent,
                   output fan_enabled, input ready);
   modport sink   (input valid, input duty, input shown_rpm, input speed_percent,
                   input fan_enabled, output ready);
endinterface

/* design/fscc_state.sv */
// Fan state registers and the per-command update logic.
module fscc_state import fscc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  func_type      func,
   input  logic [15:0]   value,
   output fan_state_type state
);

   fan_state_type state_ff, state_in;

   logic [15:0] tgt_src;
   logic [11:0] tgt_clamp;
   logic [6:0]  tgt_pct;
   logic [6:0]  pct_val;
   logic [6:0]  pct_on;
   logic [6:0]  rpm_pct;
   logic [11:0] rpm;

   // Switching on re-applies the stored target through the same clamp.
   assign tgt_src   = (func == FUNC_ON_OFF) ? 16'(state_ff.target) : value;
   assign tgt_clamp = (tgt_src < 16'(RPM_MIN)) ? RPM_MIN :
                      (tgt_src > 16'(RPM_MAX)) ? RPM_MAX : tgt_src[11:0];
   assign tgt_pct   = percent_of_target(tgt_clamp);

   assign pct_val = (value > 16'(PCT_MAX)) ? PCT_MAX : value[6:0];
   assign pct_on  = (state_ff.percent != 7'd0) ? state_ff.percent : PCT_DEFAULT;

   always_comb begin
      unique case (func)
         FUNC_PERCENT: rpm_pct = pct_val;
         FUNC_ON_OFF:  rpm_pct = pct_on;
         default:      rpm_pct = state_ff.percent;
      endcase
   end

   assign rpm = rpm_of_percent(rpm_pct);

   always_comb begin
      state_in = state_ff;
      unique case (func)
         FUNC_TARGET: begin
            if (value == 16'd0) begin
               state_in.on    = 1'b0;
               state_in.shown = 12'd0;
            end else begin
               state_in.on      = 1'b1;
               state_in.target  = tgt_clamp;
               state_in.percent = tgt_pct;
               state_in.shown   = tgt_clamp;
            end
         end
         FUNC_PERCENT: begin
            state_in.percent = pct_val;
            if (state_ff.on && pct_val != 7'd0) begin
               state_in.target = rpm;
               state_in.shown  = rpm;
            end else begin
               state_in.target = 12'd0;
               state_in.shown  = 12'd0;
            end
         end
         FUNC_ON_OFF: begin
            state_in.on = value[0];
            if (!value[0]) begin
               state_in.shown = 12'd0;
            end else if (state_ff.target != 12'd0) begin
               state_in.target  = tgt_clamp;
               state_in.percent = tgt_pct;
               state_in.shown   = tgt_clamp;
            end else begin
               state_in.percent = pct_on;
               state_in.target  = rpm;
               state_in.shown   = rpm;
            end
         end
         FUNC_REFRESH: begin
            state_in.shown = (!state_ff.on || state_ff.percent == 7'd0) ? 12'd0 : rpm;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.on      <= 1'b1;
         state_ff.percent <= PCT_RESET;
         state_ff.target  <= RPM_RESET;
         state_ff.shown   <= RPM_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      state_ff.percent <= PCT_MAX && state_ff.target <= RPM_MAX && state_ff.shown <= RPM_MAX)
      else $error("fan state out of range");

   a_shown_needs_on: assert property (@(posedge clock) disable iff (reset)
      state_ff.shown != 12'd0 |-> state_ff.on)
      else $error("nonzero shown rpm while fan off");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff))
      else $error("fan state changed without a command");

endmodule

/* design/fan_speed_command_controller.sv */
// Top level: fan speed command controller, three-stage valid/ready pipeline.
//
//   channel  | dir | handshake          | word contents
//   ---------+-----+--------------------+--------------------------------------------
//   req_if   | in  | valid/ready        | func (2b), value (16b)
//   rsp_if   | out | valid/ready        | duty (8b), shown_rpm (12b), speed_percent
//            |     |                    | (7b), fan_enabled (1b)
//   csr_*    | in  | wr_en, no back-pressure | duty_invert (1b)
//
// One word per cycle sustained while rsp_if.ready stays high; a command passes stages 1, 2 and 3 before rsp valid.
// Stage 1 holds the command word, stage 2 is the fan state itself (updated once per
// command), stage 3 is the result register where the duty is derived from the state.
// Synchronous active-high reset restores the stored defaults (on, 30 %, 800 rpm).
// A stall on rsp backs up stage by stage; req_if.ready drops only when all three hold.
module fan_speed_command_controller import fscc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fscc_req_if.sink    req_if,
   fscc_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // Pipeline valids
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;

   // Stage 1 payload
   func_type    func_ff;
   logic [15:0] value_ff;

   // Result register
   logic [7:0]  duty_ff;
   logic [11:0] shown_ff;
   logic [6:0]  percent_ff;
   logic        on_ff;

   logic invert_ff;

   logic          free3, free2, step, move2, req_fire;
   logic [7:0]    duty_raw;
   fan_state_type fan_state;

   // Stage handoff: each stage may load when its successor is empty or emptying.
   assign free3    = !v3_ff || rsp_if.ready;
   assign move2    = v2_ff && free3;
   assign free2    = !v2_ff || free3;
   assign step     = v1_ff && free2;
   assign req_fire = req_if.valid && req_if.ready;

   assign req_if.ready = !v1_ff || free2;

   always_comb begin
      v1_in = req_fire ? 1'b1 : (step ? 1'b0 : v1_ff);
      v2_in = step ? 1'b1 : (move2 ? 1'b0 : v2_ff);
      v3_in = move2 ? 1'b1 : (rsp_if.ready ? 1'b0 : v3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         invert_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         if (csr_wr_en) begin
            invert_ff <= csr_wr_data;
         end
      end
   end

   // Command word register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= func_type'(req_if.func);
         value_ff <= req_if.value;
      end
   end

   // Stage 2: fan state, advanced once per command
   fscc_state u_state (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .func  (func_ff),
      .value (value_ff),
      .state (fan_state)
   );

   // Stage 3: duty from the settled state, inverted for active-low drivers
   always_comb begin
      duty_raw = duty_of_percent(fan_state.on, fan_state.percent);
      if (invert_ff) begin
         duty_raw = DUTY_FULL - duty_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         duty_ff    <= duty_raw;
         shown_ff   <= fan_state.shown;
         percent_ff <= fan_state.percent;
         on_ff      <= fan_state.on;
      end
   end

   assign rsp_if.valid         = v3_ff;
   assign rsp_if.duty          = duty_ff;
   assign rsp_if.shown_rpm     = shown_ff;
   assign rsp_if.speed_percent = percent_ff;
   assign rsp_if.fan_enabled   = on_ff;

   // Fan off or at zero percent drives the idle level only
   a_off_idle_duty: assert property (@(posedge clock) disable iff (reset)
      v3_ff && (!on_ff || percent_ff == 7'd0) |-> duty_ff == 8'd0 || duty_ff == DUTY_FULL)
      else $error("idle duty wrong for stopped fan");

   // Running fan stays within the driver's duty window when the duty is not inverted
   a_run_duty: assert property (@(posedge clock) disable iff (reset)
      v3_ff && on_ff && percent_ff != 7'd0 && !invert_ff |->
         duty_ff >= DUTY_MIN && duty_ff <= DUTY_MAX)
      else $error("running duty outside window");

   // The state only advances when stage 2 has room
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      step |-> !v2_ff || free3)
      else $error("stage 2 overrun");

endmodule
